// ===== rtl/core/mexp_pkg.sv =====
// shared types and constants for the modular exponentiation block
// no dependencies

package mexp_pkg;

   localparam int MOD_BITS = 31;
   localparam int CNT_BITS = $clog2(MOD_BITS);

   typedef logic [MOD_BITS-1:0] word_type;

   localparam word_type EXP_RESET = word_type'(65537);
   localparam word_type MOD_RESET = word_type'(1);
   localparam word_type ONE_WORD  = word_type'(1);

   typedef enum logic [0:0] {
      CSR_EXPONENT = 1'b0,
      CSR_MODULUS  = 1'b1
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_REDUCE,
      ST_MUL,
      ST_SQR,
      ST_FIN
   } state_type;

   typedef struct packed {
      logic     start;
      word_type a;
      word_type b;
   } mul_cmd_type;

   typedef struct packed {
      logic     done;
      word_type product;
   } mul_sts_type;

   typedef struct packed {
      logic     valid;
      word_type power;
   } seq_out_type;

endpackage

// ===== rtl/core/modular_exponentiation.sv =====
// top level of the modular exponentiation block: config registers, result register
// depends on mexp_pkg, mexp_modmul and mexp_seq

// Computes message^exponent mod modulus by right-to-left square-and-multiply on one
// shared bit-serial modular multiplier, one item at a time. An item takes one
// reduction of the message, one squaring per exponent bit below the top set bit and
// one multiply per set bit; exponent zero or modulus 0 or 1 finish without using
// the multiplier. A new message transfer is taken as soon as the previous result
// reaches the output register, even if that result has not yet been taken.

module modular_exponentiation (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [30:0] req_message,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [30:0] rsp_power,
   input  logic        csr_write_en,
   input  logic        csr_index,
   input  logic [30:0] csr_wdata
);

   mexp_pkg::word_type    exponent_ff, exponent_in;
   mexp_pkg::word_type    modulus_ff, modulus_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   mexp_pkg::word_type    rsp_power_ff, rsp_power_in;

   logic                  out_free;
   mexp_pkg::seq_out_type seq_out;
   mexp_pkg::mul_cmd_type mul_cmd;
   mexp_pkg::mul_sts_type mul_sts;

   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      exponent_in = exponent_ff;
      modulus_in  = modulus_ff;
      if (csr_write_en) begin
         case (mexp_pkg::csr_index_type'(csr_index))
            mexp_pkg::CSR_EXPONENT: exponent_in = csr_wdata;
            mexp_pkg::CSR_MODULUS:  modulus_in  = csr_wdata;
            default:                exponent_in = exponent_ff;
         endcase
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_power_in = rsp_power_ff;
      if (seq_out.valid && out_free) begin
         rsp_valid_in = 1'b1;
         rsp_power_in = seq_out.power;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         exponent_ff  <= mexp_pkg::EXP_RESET;
         modulus_ff   <= mexp_pkg::MOD_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         exponent_ff  <= exponent_in;
         modulus_ff   <= modulus_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_power_ff <= rsp_power_in;
   end

   mexp_modmul u_modmul (
      .clock   (clock),
      .reset   (reset),
      .modulus (modulus_ff),
      .cmd     (mul_cmd),
      .sts     (mul_sts)
   );

   mexp_seq u_seq (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_message (req_message),
      .exponent    (exponent_ff),
      .modulus     (modulus_ff),
      .out_free    (out_free),
      .seq_out     (seq_out),
      .mul_cmd     (mul_cmd),
      .mul_sts     (mul_sts)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_power = rsp_power_ff;

   // one item at a time: no new transfer right after one is taken
   a_single_item: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request taken while an item is in flight");

   // a result is always reduced, or the exponent-zero one
   a_power_reduced: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && modulus_ff[30:1] != '0) |->
         (rsp_power < modulus_ff || rsp_power == 31'd1))
      else $error("result not below modulus");

   // degenerate modulus gives zero unless the exponent is zero
   a_unit_modulus: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && modulus_ff[30:1] == '0 && exponent_ff != '0) |-> rsp_power == '0)
      else $error("modulus 0 or 1 must give zero");

endmodule

// ===== rtl/core/mexp_modmul.sv =====
// bit-serial interleaved modular multiplier, one multiplier bit per cycle
// depends on mexp_pkg

module mexp_modmul (
   input  logic                   clock,
   input  logic                   reset,
   input  mexp_pkg::word_type     modulus,
   input  mexp_pkg::mul_cmd_type  cmd,
   output mexp_pkg::mul_sts_type  sts
);

   localparam int SUM_BITS = mexp_pkg::MOD_BITS + 2;

   logic                          run_ff, run_in;
   logic                          done_ff, done_in;
   logic [mexp_pkg::CNT_BITS-1:0] cnt_ff, cnt_in;
   mexp_pkg::word_type            r_ff, r_in;
   mexp_pkg::word_type            a_ff, a_in;
   mexp_pkg::word_type            b_ff, b_in;

   mexp_pkg::word_type            addend;
   logic [SUM_BITS-1:0]           sum;
   logic [SUM_BITS-1:0]           sub1;
   logic [SUM_BITS-1:0]           sub2;
   mexp_pkg::word_type            r_next;

   // r = 2r + bit*a, then bring back below the modulus (sum < 3m)
   always_comb begin
      addend = b_ff[mexp_pkg::MOD_BITS-1] ? a_ff : '0;
      sum    = {1'b0, r_ff, 1'b0} + {2'b00, addend};
      sub1   = sum - {2'b00, modulus};
      sub2   = sum - {1'b0, modulus, 1'b0};
      if (!sub2[SUM_BITS-1]) begin
         r_next = sub2[mexp_pkg::MOD_BITS-1:0];
      end else if (!sub1[SUM_BITS-1]) begin
         r_next = sub1[mexp_pkg::MOD_BITS-1:0];
      end else begin
         r_next = sum[mexp_pkg::MOD_BITS-1:0];
      end
   end

   always_comb begin
      run_in  = run_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      r_in    = r_ff;
      a_in    = a_ff;
      b_in    = b_ff;
      if (cmd.start) begin
         run_in = 1'b1;
         cnt_in = mexp_pkg::CNT_BITS'(mexp_pkg::MOD_BITS - 1);
         r_in   = '0;
         a_in   = cmd.a;
         b_in   = cmd.b;
      end else if (run_ff) begin
         r_in   = r_next;
         b_in   = {b_ff[mexp_pkg::MOD_BITS-2:0], 1'b0};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      r_ff   <= r_in;
      a_ff   <= a_in;
      b_ff   <= b_in;
   end

   assign sts.done    = done_ff;
   assign sts.product = r_ff;

endmodule

// ===== rtl/core/mexp_seq.sv =====
// square-and-multiply sequencer driving the shared modular multiplier
// depends on mexp_pkg

module mexp_seq (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  mexp_pkg::word_type     req_message,
   input  mexp_pkg::word_type     exponent,
   input  mexp_pkg::word_type     modulus,
   input  logic                   out_free,
   output mexp_pkg::seq_out_type  seq_out,
   output mexp_pkg::mul_cmd_type  mul_cmd,
   input  mexp_pkg::mul_sts_type  mul_sts
);

   mexp_pkg::state_type state_ff, state_in;
   logic                launch_ff, launch_in;
   mexp_pkg::word_type  acc_ff, acc_in;
   mexp_pkg::word_type  base_ff, base_in;
   mexp_pkg::word_type  exp_ff, exp_in;

   logic                trivial;
   logic                exp_rest_zero;

   assign trivial       = (exponent == '0) || (modulus[mexp_pkg::MOD_BITS-1:1] == '0);
   assign exp_rest_zero = (exp_ff[mexp_pkg::MOD_BITS-1:1] == '0);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         mexp_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = trivial ? mexp_pkg::ST_FIN : mexp_pkg::ST_REDUCE;
            end
         end
         mexp_pkg::ST_REDUCE: begin
            if (mul_sts.done) begin
               state_in = exp_ff[0] ? mexp_pkg::ST_MUL : mexp_pkg::ST_SQR;
            end
         end
         mexp_pkg::ST_MUL: begin
            if (mul_sts.done) begin
               state_in = exp_rest_zero ? mexp_pkg::ST_FIN : mexp_pkg::ST_SQR;
            end
         end
         mexp_pkg::ST_SQR: begin
            if (mul_sts.done) begin
               state_in = exp_ff[1] ? mexp_pkg::ST_MUL : mexp_pkg::ST_SQR;
            end
         end
         mexp_pkg::ST_FIN: begin
            if (out_free) begin
               state_in = mexp_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = mexp_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_ready     = 1'b0;
      seq_out.valid = 1'b0;
      seq_out.power = acc_ff;
      mul_cmd.start = launch_ff;
      mul_cmd.a     = acc_ff;
      mul_cmd.b     = base_ff;
      launch_in     = 1'b0;
      acc_in        = acc_ff;
      base_in       = base_ff;
      exp_in        = exp_ff;
      case (state_ff)
         mexp_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               exp_in    = exponent;
               base_in   = req_message;
               // exponent zero gives 1 even for modulus 0 or 1
               acc_in    = (exponent == '0) ? mexp_pkg::ONE_WORD :
                           (trivial ? '0 : mexp_pkg::ONE_WORD);
               launch_in = !trivial;
            end
         end
         mexp_pkg::ST_REDUCE: begin
            // base mod m computed as 1 * base
            mul_cmd.a = mexp_pkg::ONE_WORD;
            mul_cmd.b = base_ff;
            if (mul_sts.done) begin
               base_in   = mul_sts.product;
               launch_in = 1'b1;
            end
         end
         mexp_pkg::ST_MUL: begin
            mul_cmd.a = acc_ff;
            mul_cmd.b = base_ff;
            if (mul_sts.done) begin
               acc_in    = mul_sts.product;
               launch_in = !exp_rest_zero;
            end
         end
         mexp_pkg::ST_SQR: begin
            mul_cmd.a = base_ff;
            mul_cmd.b = base_ff;
            if (mul_sts.done) begin
               base_in   = mul_sts.product;
               exp_in    = {1'b0, exp_ff[mexp_pkg::MOD_BITS-1:1]};
               launch_in = 1'b1;
            end
         end
         mexp_pkg::ST_FIN: begin
            seq_out.valid = 1'b1;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= mexp_pkg::ST_IDLE;
         launch_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         launch_ff <= launch_in;
      end
      acc_ff  <= acc_in;
      base_ff <= base_in;
      exp_ff  <= exp_in;
   end

endmodule
